/* rtl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and fixed field widths shared by the page frame allocator files.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MODE_W   = 2;
  localparam int SIZE_W   = 12;
  localparam int PSZ_W    = 7;
  localparam int SLOT_W   = 4;
  localparam int FRAME_W  = 6;
  localparam int PIDX_W   = 5;
  localparam int STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_FEW   = 3'd1,
    STAT_SPACE = 3'd2,
    STAT_DEAD  = 3'd3,
    STAT_ZERO  = 3'd4,
    STAT_FULL  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ACHK,
    S_ARD,
    S_AEMIT,
    S_RCHK,
    S_RRD,
    S_RPUSH,
    S_ADD,
    S_RES
  } fsm_e;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [PSZ_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/pfa_divider.sv */
// ----------------------------------------------------------------------------
// pfa_divider
// Restoring divider, one quotient bit per cycle; quotient holds until restart.
// ----------------------------------------------------------------------------
module pfa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfa_pkg::div_req_t  req_i,
  output pfa_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(pfa_pkg::SIZE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pfa_pkg::SIZE_W - 1);

  logic                        run_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [pfa_pkg::PSZ_W-1:0]   rem_q;
  logic [pfa_pkg::PSZ_W-1:0]   dvs_q;
  logic [pfa_pkg::SIZE_W-1:0]  quo_q;
  logic [pfa_pkg::PSZ_W:0]     trial;
  logic [pfa_pkg::PSZ_W:0]     diff;
  logic                        take;

  always_comb begin
    trial = {rem_q, quo_q[pfa_pkg::SIZE_W-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == LAST_STEP);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Shift the dividend out of the quotient register as quotient bits come in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (run_q) begin
      rem_q <= take ? diff[pfa_pkg::PSZ_W-1:0] : trial[pfa_pkg::PSZ_W-1:0];
      quo_q <= {quo_q[pfa_pkg::SIZE_W-2:0], take};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/page_frame_allocator.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator
// Paging frame allocator: free frame ring, frame table and process slots.
// ----------------------------------------------------------------------------
// Sequence: allocate runs the bit-serial page count division and the checks,
//   then reads and emits each page in turn, paced by the registered read of
//   the free ring; a failed allocate goes from the checks to one result.
//   Release walks its frames one by one, paced by the frame table read port.
//   Add frame checks, pushes the frame and then returns one result.
// Throughput: one item at a time; ready is high only between items.
// Reset: counters, slot live bits and control clear at once; no memory sweep.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
  parameter int FREE_DEPTH  = 32,
  parameter int TABLE_DEPTH = 64,
  parameter int SLOT_COUNT  = 16,
  parameter int FRAME_LIMIT = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [pfa_pkg::PSZ_W-1:0]      cfg_wdata_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pfa_pkg::MODE_W-1:0]     mode_i,
  input  logic [pfa_pkg::SIZE_W-1:0]     process_size_kb_i,
  input  logic [pfa_pkg::SLOT_W-1:0]     process_slot_i,
  input  logic [pfa_pkg::FRAME_W-1:0]    frame_number_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pfa_pkg::STATUS_W-1:0]   status_o,
  output logic [pfa_pkg::SLOT_W-1:0]     assigned_slot_o,
  output logic [pfa_pkg::PIDX_W-1:0]     page_index_o,
  output logic [pfa_pkg::FRAME_W-1:0]    frame_out_o,
  output logic                           last_o
);

  // Widths that follow from the storage depths.
  localparam int RI_W   = $clog2(FREE_DEPTH);       // ring index
  localparam int CNT_W  = $clog2(FREE_DEPTH + 1);   // ring fill, page counts
  localparam int SUMC_W = CNT_W + 1;                // head + count, count + n
  localparam int TI_W   = $clog2(TABLE_DEPTH);      // table index
  localparam int TF_W   = $clog2(TABLE_DEPTH + 1);  // table fill
  localparam int SL_W   = $clog2(SLOT_COUNT);       // slot index
  localparam int NS_W   = $clog2(SLOT_COUNT + 1);   // next slot
  localparam int PG_W   = pfa_pkg::SIZE_W;          // page count from divider
  localparam int SUMT_W = ((TF_W > PG_W) ? TF_W : PG_W) + 1;

  localparam int FW = pfa_pkg::FRAME_W;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pfa_pkg::fsm_e              state_q, state_d;
  logic [pfa_pkg::PSZ_W-1:0]  psz_cfg_q;
  logic [RI_W-1:0]            head_q;
  logic [CNT_W-1:0]           count_q;
  logic [TF_W-1:0]            fill_q;
  logic [NS_W-1:0]            next_slot_q;
  logic [SLOT_COUNT-1:0]      slot_live_q;
  logic [CNT_W-1:0]           idx_q;

  logic [TI_W-1:0]            slot_base_q  [SLOT_COUNT];
  logic [CNT_W-1:0]           slot_pages_q [SLOT_COUNT];

  // captured input item
  logic [pfa_pkg::SLOT_W-1:0] slot_q;
  logic [FW-1:0]              frame_q;

  // release walk
  logic [TI_W-1:0]            rel_ptr_q;
  logic [CNT_W-1:0]           rel_n_q;

  // single-result fields
  pfa_pkg::status_e           res_status_q;
  logic [pfa_pkg::SLOT_W-1:0] res_slot_q;
  logic [FW-1:0]              res_frame_q;

  // output register
  logic                       out_valid_q;
  pfa_pkg::status_e           out_status_q;
  logic [pfa_pkg::SLOT_W-1:0] out_slot_q;
  logic [pfa_pkg::PIDX_W-1:0] out_page_q;
  logic [FW-1:0]              out_frame_q;
  logic                       out_last_q;

  // memories
  logic [FW-1:0]              ring_mem  [FREE_DEPTH];
  logic [FW-1:0]              table_mem [TABLE_DEPTH];
  logic [FW-1:0]              ring_rdata_q;
  logic [FW-1:0]              tbl_rdata_q;

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  pfa_pkg::div_req_t div_req;
  pfa_pkg::div_rsp_t div_rsp;
  logic [PG_W-1:0]   pages;

  pfa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pages = div_rsp.quotient;

  // --------------------------------------------------------------------------
  // Decision terms
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic             out_free;
  logic             a_zero, a_few, a_space, a_fail, a_last;
  pfa_pkg::status_e a_status;
  logic [SL_W-1:0]  ns_idx;
  logic [SL_W-1:0]  rel_idx;
  logic             rel_oob, rel_dead, rel_full, rel_fail, r_last;
  pfa_pkg::status_e r_status;
  logic             add_fail;
  logic [SUMC_W-1:0] tail_sum;
  logic [RI_W-1:0]  tail;
  logic [RI_W-1:0]  head_inc;

  always_comb begin
    in_acc   = in_ready_o && in_valid_i;
    out_free = !out_valid_q || out_ready_i;

    // allocate checks, in priority order
    a_zero   = pages == '0;
    a_few    = pages > PG_W'(count_q);
    a_space  = (next_slot_q >= NS_W'(SLOT_COUNT)) ||
               ((SUMT_W'(fill_q) + SUMT_W'(pages)) > SUMT_W'(TABLE_DEPTH));
    a_fail   = a_zero || a_few || a_space;
    a_status = a_zero ? pfa_pkg::STAT_ZERO :
               a_few  ? pfa_pkg::STAT_FEW  : pfa_pkg::STAT_SPACE;
    a_last   = (PG_W'(idx_q) + PG_W'(1)) == pages;
    ns_idx   = next_slot_q[SL_W-1:0];

    // release checks
    rel_idx  = SL_W'(slot_q);
    rel_oob  = 32'(slot_q) >= 32'(SLOT_COUNT);
    rel_dead = rel_oob || !slot_live_q[rel_idx];
    rel_full = (SUMC_W'(count_q) + SUMC_W'(slot_pages_q[rel_idx])) >
               SUMC_W'(FREE_DEPTH);
    rel_fail = rel_dead || rel_full;
    r_status = rel_dead ? pfa_pkg::STAT_DEAD : pfa_pkg::STAT_FULL;
    r_last   = (idx_q + CNT_W'(1)) == rel_n_q;

    // add check
    add_fail = (count_q >= CNT_W'(FREE_DEPTH)) ||
               (32'(frame_q) > 32'(FRAME_LIMIT));

    // ring pointers, wrapped at the depth
    tail_sum = SUMC_W'(head_q) + SUMC_W'(count_q);
    if (tail_sum >= SUMC_W'(FREE_DEPTH)) begin
      tail = RI_W'(tail_sum - SUMC_W'(FREE_DEPTH));
    end else begin
      tail = RI_W'(tail_sum);
    end
    head_inc = (head_q == RI_W'(FREE_DEPTH - 1)) ? '0 : head_q + RI_W'(1);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            pfa_pkg::MODE_ALLOC:   state_d = pfa_pkg::S_DIV;
            pfa_pkg::MODE_RELEASE: state_d = pfa_pkg::S_RCHK;
            pfa_pkg::MODE_ADD:     state_d = pfa_pkg::S_ADD;
            default:               state_d = pfa_pkg::S_IDLE;
          endcase
        end
      end
      pfa_pkg::S_DIV: begin
        if (div_rsp.done) state_d = pfa_pkg::S_ACHK;
      end
      pfa_pkg::S_ACHK: begin
        state_d = a_fail ? pfa_pkg::S_RES : pfa_pkg::S_ARD;
      end
      pfa_pkg::S_ARD:  state_d = pfa_pkg::S_AEMIT;
      pfa_pkg::S_AEMIT: begin
        if (out_free) state_d = a_last ? pfa_pkg::S_IDLE : pfa_pkg::S_ARD;
      end
      pfa_pkg::S_RCHK: begin
        state_d = rel_fail ? pfa_pkg::S_RES : pfa_pkg::S_RRD;
      end
      pfa_pkg::S_RRD:  state_d = pfa_pkg::S_RPUSH;
      pfa_pkg::S_RPUSH: begin
        state_d = r_last ? pfa_pkg::S_RES : pfa_pkg::S_RRD;
      end
      pfa_pkg::S_ADD:  state_d = pfa_pkg::S_RES;
      pfa_pkg::S_RES: begin
        if (out_free) state_d = pfa_pkg::S_IDLE;
      end
      default:         state_d = pfa_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs
  // --------------------------------------------------------------------------
  logic in_ready, div_start, a_fail_do, a_commit, a_emit;
  logic r_fail_do, r_commit, r_push, add_do, res_out;

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    a_fail_do = 1'b0;
    a_commit  = 1'b0;
    a_emit    = 1'b0;
    r_fail_do = 1'b0;
    r_commit  = 1'b0;
    r_push    = 1'b0;
    add_do    = 1'b0;
    res_out   = 1'b0;
    case (state_q)
      pfa_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid_i && (mode_i == pfa_pkg::MODE_ALLOC);
      end
      pfa_pkg::S_ACHK: begin
        a_fail_do = a_fail;
        a_commit  = !a_fail;
      end
      pfa_pkg::S_AEMIT: a_emit = out_free;
      pfa_pkg::S_RCHK: begin
        r_fail_do = rel_fail;
        r_commit  = !rel_fail;
      end
      pfa_pkg::S_RPUSH: r_push  = 1'b1;
      pfa_pkg::S_ADD:   add_do  = 1'b1;
      pfa_pkg::S_RES:   res_out = out_free;
      default: ;
    endcase
  end

  assign in_ready_o = in_ready;

  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = process_size_kb_i;
    // a zero page size divides as one
    div_req.divisor  = (psz_cfg_q == '0) ? pfa_pkg::PSZ_W'(1) : psz_cfg_q;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::S_IDLE;
      psz_cfg_q   <= pfa_pkg::PSZ_W'(1);
      head_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      next_slot_q <= '0;
      slot_live_q <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) psz_cfg_q <= cfg_wdata_i;

      // Claim the slot once all checks pass; pages follow one by one.
      if (a_commit) begin
        slot_live_q[ns_idx] <= 1'b1;
        idx_q               <= '0;
      end
      if (a_emit) begin
        head_q  <= head_inc;
        count_q <= count_q - CNT_W'(1);
        fill_q  <= fill_q + TF_W'(1);
        idx_q   <= idx_q + CNT_W'(1);
        if (a_last) next_slot_q <= next_slot_q + NS_W'(1);
      end

      if (r_commit) idx_q <= '0;
      if (r_push) begin
        count_q <= count_q + CNT_W'(1);
        idx_q   <= idx_q + CNT_W'(1);
        if (r_last) slot_live_q[rel_idx] <= 1'b0;
      end

      if (add_do && !add_fail) count_q <= count_q + CNT_W'(1);

      if (a_emit || res_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q  <= process_slot_i;
      frame_q <= frame_number_i;
    end

    if (a_commit) begin
      slot_base_q[ns_idx]  <= fill_q[TI_W-1:0];
      slot_pages_q[ns_idx] <= CNT_W'(pages);
    end

    if (r_commit) begin
      rel_ptr_q <= slot_base_q[rel_idx];
      rel_n_q   <= slot_pages_q[rel_idx];
    end
    if (r_push) rel_ptr_q <= rel_ptr_q + TI_W'(1);

    // Stage the one-result answers.
    if (a_fail_do) begin
      res_status_q <= a_status;
      res_slot_q   <= '0;
      res_frame_q  <= '0;
    end
    if (r_fail_do) begin
      res_status_q <= r_status;
      res_slot_q   <= slot_q;
      res_frame_q  <= '0;
    end
    if (r_push && r_last) begin
      res_status_q <= pfa_pkg::STAT_OK;
      res_slot_q   <= slot_q;
      res_frame_q  <= '0;
    end
    if (add_do) begin
      res_status_q <= add_fail ? pfa_pkg::STAT_FULL : pfa_pkg::STAT_OK;
      res_slot_q   <= '0;
      res_frame_q  <= frame_q;
    end

    if (a_emit) begin
      out_status_q <= pfa_pkg::STAT_OK;
      out_slot_q   <= pfa_pkg::SLOT_W'(next_slot_q);
      out_page_q   <= pfa_pkg::PIDX_W'(idx_q);
      out_frame_q  <= ring_rdata_q;
      out_last_q   <= a_last;
    end else if (res_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_page_q   <= '0;
      out_frame_q  <= res_frame_q;
      out_last_q   <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Free ring: push at the tail, registered read at the head
  // --------------------------------------------------------------------------
  logic          ring_we;
  logic [FW-1:0] ring_wdata;

  assign ring_we    = r_push || (add_do && !add_fail);
  assign ring_wdata = r_push ? tbl_rdata_q : frame_q;

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[tail] <= ring_wdata;
    ring_rdata_q <= ring_mem[head_q];
  end

  // --------------------------------------------------------------------------
  // Frame table: append at the fill point, registered read for release
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (a_emit) table_mem[fill_q[TI_W-1:0]] <= ring_rdata_q;
    tbl_rdata_q <= table_mem[rel_ptr_q];
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign assigned_slot_o = out_slot_q;
  assign page_index_o    = out_page_q;
  assign frame_out_o     = out_frame_q;
  assign last_o          = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FREE_DEPTH))
    else $error("free ring count above depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TF_W'(TABLE_DEPTH))
    else $error("frame table fill above depth");

  a_emit_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_emit |-> (count_q != '0))
    else $error("page emitted from an empty free ring");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_push |-> (count_q < CNT_W'(FREE_DEPTH)))
    else $error("release pushed into a full free ring");

endmodule
